// ===== hw/rtl/flash_write_chunker_core_assert.svh =====
// Assertion macros shared by the flash write chunker RTL.
`ifndef FLASH_WRITE_CHUNKER_CORE_ASSERT_SVH
`define FLASH_WRITE_CHUNKER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FWC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flash write chunker: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define FWC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flash write chunker: next-cycle check failed");

`endif

// ===== hw/rtl/fwc_pkg.sv =====
// Types and constants of the flash write chunker.
`default_nettype none

package fwc_pkg;

    // Erase granule; a power of two, so the page offset is a mask.
    localparam int unsigned PAGE_BYTES       = 8192;
    localparam logic [31:0] PAGE_OFFSET_MASK = 32'(PAGE_BYTES - 1);

    localparam logic [4:0] BURST_BYTES = 5'd16;
    localparam logic [4:0] WORD_BYTES  = 5'd4;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_DATA  = 2'd1,
        FUNC_ERASE = 2'd2
    } fwc_func_t;

    typedef enum logic [1:0] {
        KIND_WORD  = 2'd0,
        KIND_BURST = 2'd1,
        KIND_ERASE = 2'd2
    } fwc_kind_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] address;
        logic [23:0] length;
        logic [7:0]  data_byte;
        logic [31:0] flash_word;
    } fwc_item_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [31:0] cmd_address;
        logic [63:0] data_low;
        logic [63:0] data_high;
        logic        final_command;
    } fwc_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fwc_req_if.sv =====
// Request channel: start, data and erase items.
`default_nettype none

interface fwc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] address;
    logic [23:0] length;
    logic [7:0]  data_byte;
    logic [31:0] flash_word;

    modport source (output valid, func, address, length, data_byte, flash_word, input ready);
    modport sink   (input valid, func, address, length, data_byte, flash_word, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fwc_cmd_if.sv =====
// Command channel: word writes, burst writes and page erases.
`default_nettype none

interface fwc_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] cmd_address;
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic        final_command;

    modport source (output valid, kind, cmd_address, data_low, data_high, final_command,
                    input ready);
    modport sink   (input valid, kind, cmd_address, data_low, data_high, final_command,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fwc_chunker.sv =====
// Write request state and chunk packing for one item per cycle.
`default_nettype none
`include "flash_write_chunker_core_assert.svh"

module fwc_chunker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire fwc_pkg::fwc_item_t item,
    output fwc_pkg::fwc_cmd_t      result
);
    import fwc_pkg::*;

    logic         active_reg,  active_next;
    logic         phase_reg,   phase_next;
    logic [4:0]   fill_reg,    fill_next;
    logic [31:0]  nba_reg,     nba_next;
    logic [23:0]  rem_reg,     rem_next;
    logic [31:0]  base_reg,    base_next;
    logic [4:0]   bytes_reg,   bytes_next;
    logic [127:0] buf_reg,     buf_next;

    logic [31:0]  cur_base;
    logic [4:0]   cur_bytes;
    logic         cur_phase;
    logic [127:0] cur_buf;
    logic [2:0]   gap;
    logic [3:0]   lane;
    logic [127:0] merged;
    logic [4:0]   fill_inc;
    logic [23:0]  rem_dec;
    logic         done;

    // Open a chunk on its first byte, otherwise carry on with the held one.
    always_comb
    begin
        gap       = 3'd4 - {1'b0, nba_reg[1:0]};
        cur_base  = base_reg;
        cur_bytes = bytes_reg;
        cur_phase = phase_reg;
        cur_buf   = buf_reg;
        if (fill_reg == 5'd0)
        begin
            priority if (nba_reg[1:0] != 2'd0)
            begin
                cur_base  = {nba_reg[31:2], 2'b00};
                cur_bytes = (rem_reg < {21'd0, gap}) ? rem_reg[4:0] : {2'b00, gap};
                cur_phase = 1'b0;
            end
            else if (rem_reg >= {19'd0, BURST_BYTES} && (phase_reg || nba_reg[4:0] == 5'd0))
            begin
                cur_base  = nba_reg;
                cur_bytes = BURST_BYTES;
                cur_phase = 1'b1;
            end
            else
            begin
                cur_base  = nba_reg;
                cur_bytes = (rem_reg < {19'd0, WORD_BYTES}) ? rem_reg[4:0] : WORD_BYTES;
                cur_phase = 1'b0;
            end
            cur_buf = (cur_bytes == BURST_BYTES) ? 128'd0 : {96'd0, item.flash_word};
        end
    end

    assign lane     = nba_reg[3:0] - cur_base[3:0];
    assign fill_inc = fill_reg + 5'd1;
    assign rem_dec  = rem_reg - 24'd1;
    assign done     = (fill_inc >= cur_bytes);

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            merged[8*i +: 8] = (lane == 4'(i)) ? item.data_byte : cur_buf[8*i +: 8];
        end
    end

    always_comb
    begin
        active_next = active_reg;
        phase_next  = phase_reg;
        fill_next   = fill_reg;
        nba_next    = nba_reg;
        rem_next    = rem_reg;
        base_next   = base_reg;
        bytes_next  = bytes_reg;
        buf_next    = buf_reg;
        result      = '0;
        unique case (item.func)
            FUNC_START:
            begin
                active_next = (item.length != 24'd0);
                nba_next    = item.address;
                rem_next    = item.length;
                phase_next  = 1'b0;
                fill_next   = 5'd0;
            end
            FUNC_DATA:
            begin
                if (active_reg)
                begin
                    base_next  = cur_base;
                    bytes_next = cur_bytes;
                    buf_next   = merged;
                    phase_next = cur_phase;
                    nba_next   = nba_reg + 32'd1;
                    rem_next   = rem_dec;
                    fill_next  = done ? 5'd0 : fill_inc;
                    if (done)
                    begin
                        result.valid         = 1'b1;
                        result.cmd_address   = cur_base;
                        result.final_command = (rem_dec == 24'd0);
                        if (cur_bytes == BURST_BYTES)
                        begin
                            result.kind      = KIND_BURST;
                            result.data_low  = merged[63:0];
                            result.data_high = merged[127:64];
                        end
                        else
                        begin
                            result.kind     = KIND_WORD;
                            result.data_low = {32'd0, merged[31:0]};
                        end
                        if (rem_dec == 24'd0)
                        begin
                            active_next = 1'b0;
                            phase_next  = 1'b0;
                        end
                    end
                end
            end
            FUNC_ERASE:
            begin
                result.valid         = 1'b1;
                result.kind          = KIND_ERASE;
                result.cmd_address   = item.address & ~PAGE_OFFSET_MASK;
                result.final_command = 1'b1;
            end
            default:
            begin
                // Unused code: drop.
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            phase_reg  <= 1'b0;
            fill_reg   <= 5'd0;
            nba_reg    <= 32'd0;
            rem_reg    <= 24'd0;
        end
        else if (step)
        begin
            active_reg <= active_next;
            phase_reg  <= phase_next;
            fill_reg   <= fill_next;
            nba_reg    <= nba_next;
            rem_reg    <= rem_next;
        end
    end

    // Chunk payload is reloaded whenever a chunk opens and updated with every data byte.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            base_reg  <= base_next;
            bytes_reg <= bytes_next;
            buf_reg   <= buf_next;
        end
    end

    `FWC_ASSERT_NOW(a_idle_no_fill, !active_reg, fill_reg == 5'd0 && !phase_reg)
    `FWC_ASSERT_NOW(a_fill_below_size, active_reg && fill_reg != 5'd0,
                    fill_reg < bytes_reg && bytes_reg <= BURST_BYTES)
    `FWC_ASSERT_NEXT(a_start_clears, step && item.func == FUNC_START, fill_reg == 5'd0)

endmodule

`default_nettype wire

// ===== hw/rtl/flash_write_chunker_core.sv =====
// Top level of the flash write chunker: request register, chunker, command register.
`default_nettype none
`include "flash_write_chunker_core_assert.svh"

// Turns flash write and erase requests into controller commands. A start item opens a
// write of length bytes at address; data items then bring one byte each, and every
// completed chunk leaves as one command: a word write for an unaligned head, a short
// tail or an aligned word outside a burst (unused lanes from flash_word), or a 16-byte
// burst once 32-byte aligned with at least 16 bytes left. An erase item gives one page
// erase at once. The block takes one item per cycle while the command side does not
// stall; a command passes the request register, then the command register, on its way
// to the command port. The chunk decision and byte merge are combinational logic
// between those two registers, and a stalled command register holds the request
// register, so a stall on the command side costs no item.
module flash_write_chunker_core (
    input  wire logic clk,
    input  wire logic rst_n,
    fwc_req_if.sink   req,
    fwc_cmd_if.source cmd
);
    import fwc_pkg::*;

    logic      item_valid_reg;
    fwc_item_t item_reg;
    logic      cmd_valid_reg;
    fwc_cmd_t  cmd_reg;
    fwc_cmd_t  result;
    logic      advance;

    // Move the held item on when the command register is free or being emptied.
    assign advance   = item_valid_reg && (!cmd_valid_reg || cmd.ready);
    assign req.ready = !item_valid_reg || advance;

    fwc_chunker u_chunker (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            cmd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                cmd_valid_reg <= result.valid;
            end
            else if (cmd.ready)
            begin
                cmd_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg.func       <= req.func;
            item_reg.address    <= req.address;
            item_reg.length     <= req.length;
            item_reg.data_byte  <= req.data_byte;
            item_reg.flash_word <= req.flash_word;
        end
        if (advance)
        begin
            cmd_reg <= result;
        end
    end

    assign cmd.valid         = cmd_valid_reg;
    assign cmd.kind          = cmd_reg.kind;
    assign cmd.cmd_address   = cmd_reg.cmd_address;
    assign cmd.data_low      = cmd_reg.data_low;
    assign cmd.data_high     = cmd_reg.data_high;
    assign cmd.final_command = cmd_reg.final_command;

    `FWC_ASSERT_NOW(a_erase_shape, cmd_valid_reg && cmd_reg.kind == KIND_ERASE,
                    cmd_reg.final_command && cmd_reg.data_low == 64'd0 &&
                    cmd_reg.data_high == 64'd0 && (cmd_reg.cmd_address & PAGE_OFFSET_MASK) == 32'd0)
    `FWC_ASSERT_NOW(a_word_shape, cmd_valid_reg && cmd_reg.kind == KIND_WORD,
                    cmd_reg.data_low[63:32] == 32'd0 && cmd_reg.data_high == 64'd0 &&
                    cmd_reg.cmd_address[1:0] == 2'd0)
    `FWC_ASSERT_NOW(a_burst_aligned, cmd_valid_reg && cmd_reg.kind == KIND_BURST,
                    cmd_reg.cmd_address[3:0] == 4'd0)

endmodule

`default_nettype wire

// ===== sim/flash_write_chunker_core_test.sv =====
// Self-checking testbench of the flash write chunker: directed and random requests.
`default_nettype none

module flash_write_chunker_core_test;
    import fwc_pkg::*;

    localparam logic [1:0] FUNC_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS  = 1700;
    localparam int         PHASE_ITEMS   = 200;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] cmd_address;
        logic [63:0] data_low;
        logic [63:0] data_high;
        logic        final_command;
    } cmd_fields_t;

    // Chunker state mirrored from the transfers seen on the request side.
    class cmd_board;
        bit           write_open = 1'b0;
        bit           burst_run  = 1'b0;
        logic [31:0]  next_addr  = '0;
        logic [23:0]  remaining  = '0;
        logic [31:0]  chunk_base = '0;
        logic [4:0]   chunk_need = '0;
        logic [4:0]   chunk_fill = '0;
        logic [127:0] chunk_buf  = '0;
        cmd_fields_t  expected_cmds[$];
        int unsigned  failures   = 0;

        function void clear_chunk();
            chunk_base = '0;
            chunk_need = '0;
            chunk_fill = '0;
            chunk_buf  = '0;
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction

        function void note_request(fwc_item_t it);
            cmd_fields_t want;
            logic [31:0] offs;
            logic [2:0]  gap;
            if (it.func == FUNC_START)
            begin
                write_open = (it.length != '0);
                next_addr  = it.address;
                remaining  = it.length;
                burst_run  = 1'b0;
                clear_chunk();
            end
            else if (it.func == FUNC_ERASE)
            begin
                want.kind          = KIND_ERASE;
                want.cmd_address   = it.address & ~PAGE_OFFSET_MASK;
                want.data_low      = '0;
                want.data_high     = '0;
                want.final_command = 1'b1;
                expected_cmds.push_back(want);
            end
            else if (it.func == FUNC_DATA && write_open)
            begin
                if (chunk_fill == '0)
                begin
                    // Decide the chunk shape on its first byte.
                    gap = 3'd4 - {1'b0, next_addr[1:0]};
                    if (next_addr[1:0] != 2'b00)
                    begin
                        chunk_base = {next_addr[31:2], 2'b00};
                        chunk_need = (remaining < gap) ? 5'(remaining) : 5'(gap);
                        burst_run  = 1'b0;
                    end
                    else if (remaining >= BURST_BYTES
                             && (burst_run || next_addr[4:0] == 5'd0))
                    begin
                        chunk_base = next_addr;
                        chunk_need = BURST_BYTES;
                        burst_run  = 1'b1;
                    end
                    else
                    begin
                        chunk_base = next_addr;
                        chunk_need = (remaining < WORD_BYTES) ? 5'(remaining) : WORD_BYTES;
                        burst_run  = 1'b0;
                    end
                    chunk_buf = (chunk_need == BURST_BYTES) ? '0 : {96'd0, it.flash_word};
                end
                offs = next_addr - chunk_base;
                chunk_buf[{offs[3:0], 3'b000} +: 8] = it.data_byte;
                chunk_fill = chunk_fill + 5'd1;
                next_addr  = next_addr + 32'd1;
                remaining  = remaining - 24'd1;
                if (chunk_fill >= chunk_need)
                begin
                    want.kind          = (chunk_need == BURST_BYTES) ? KIND_BURST : KIND_WORD;
                    want.cmd_address   = chunk_base;
                    want.data_low      = (chunk_need == BURST_BYTES) ? chunk_buf[63:0]
                                                                     : {32'd0, chunk_buf[31:0]};
                    want.data_high     = (chunk_need == BURST_BYTES) ? chunk_buf[127:64] : '0;
                    want.final_command = (remaining == '0);
                    expected_cmds.push_back(want);
                    if (remaining == '0)
                    begin
                        write_open = 1'b0;
                        burst_run  = 1'b0;
                    end
                    clear_chunk();
                end
            end
        endfunction

        function void check_command(cmd_fields_t got);
            cmd_fields_t want;
            if (expected_cmds.size() == 0)
            begin
                $error("unexpected command: kind %0d address %h", got.kind, got.cmd_address);
                failures++;
                return;
            end
            want = expected_cmds.pop_front();
            if (got.kind !== want.kind)
            begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                failures++;
            end
            if (got.cmd_address !== want.cmd_address)
            begin
                $error("cmd_address: expected %h, got %h", want.cmd_address, got.cmd_address);
                failures++;
            end
            if (got.data_low !== want.data_low)
            begin
                $error("data_low: expected %h, got %h", want.data_low, got.data_low);
                failures++;
            end
            if (got.data_high !== want.data_high)
            begin
                $error("data_high: expected %h, got %h", want.data_high, got.data_high);
                failures++;
            end
            if (got.final_command !== want.final_command)
            begin
                $error("final_command: expected %0d, got %0d",
                       want.final_command, got.final_command);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    fwc_req_if req_ch ();
    fwc_cmd_if cmd_ch ();

    flash_write_chunker_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .cmd   (cmd_ch)
    );

    cmd_board board = new;
    int       items_sent   = 0;
    bit       req_idle_on  = 1'b0;
    bit       sink_idle_on = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("** flash_write_chunker_core: FAILED **");
        $finish;
    end

    function int pick_gap(bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Command side: check each transfer, then choose next cycle's ready.
    initial
    begin : cmd_sink
        int          stall_left;
        cmd_fields_t got;
        stall_left = 0;
        cmd_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1)
            begin
                got.kind          = cmd_ch.kind;
                got.cmd_address   = cmd_ch.cmd_address;
                got.data_low      = cmd_ch.data_low;
                got.data_high     = cmd_ch.data_high;
                got.final_command = cmd_ch.final_command;
                board.check_command(got);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                cmd_ch.ready <= 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 99) < 20)
            begin
                stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                        : $urandom_range(9, 40);
                cmd_ch.ready <= 1'b0;
            end
            else
                cmd_ch.ready <= 1'b1;
        end
    end

    task automatic send_item(input logic [1:0] f, input logic [31:0] a,
                             input logic [23:0] len, input logic [7:0] b,
                             input logic [31:0] w);
        fwc_item_t it;
        int        gap;
        it.func       = f;
        it.address    = a;
        it.length     = len;
        it.data_byte  = b;
        it.flash_word = w;
        gap = pick_gap(req_idle_on);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.func       <= it.func;
        req_ch.address    <= it.address;
        req_ch.length     <= it.length;
        req_ch.data_byte  <= it.data_byte;
        req_ch.flash_word <= it.flash_word;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        board.note_request(it);
        items_sent++;
    endtask

    task automatic start_write(input logic [31:0] a, input logic [23:0] len);
        send_item(FUNC_START, a, len, 8'($urandom), $urandom);
    endtask

    task automatic data_byte(input logic [7:0] b, input logic [31:0] w);
        send_item(FUNC_DATA, $urandom, 24'($urandom), b, w);
    endtask

    task automatic erase_page(input logic [31:0] a);
        send_item(FUNC_ERASE, a, 24'($urandom), 8'($urandom), $urandom);
    endtask

    task automatic stray_item();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
            send_item(FUNC_UNUSED, $urandom, 24'($urandom), 8'($urandom), $urandom);
        else if (r == 1)
            data_byte(8'($urandom), $urandom);
        else
            erase_page($urandom);
    endtask

    // Hold the request side until every command owed has been taken.
    task automatic settle();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    task automatic write_request(input logic [31:0] a, input logic [23:0] len,
                                 input int supplied);
        int i;
        start_write(a, len);
        for (i = 0; i < supplied; i++)
        begin
            if ($urandom_range(0, 99) < 3)
                stray_item();
            data_byte(8'($urandom), $urandom);
        end
    endtask

    function logic [31:0] pick_address();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return ($urandom & 32'hFFFF_FFE0)
                   | (($urandom_range(0, 7) < 5) ? $urandom_range(0, 3) : $urandom_range(0, 31));
        else if (r < 8)
            return $urandom;
        else if (r == 8)
            return 32'hFFFF_FFFF - $urandom_range(0, 63);
        else
            return $urandom_range(0, 63);
    endfunction

    function logic [23:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 24'($urandom_range(1, 40));
        else if (r < 75)
            return 24'($urandom_range(0, 4));
        else
            return 24'($urandom_range(16, 96));
    endfunction

    initial
    begin : stimulus
        int          next_phase_at;
        int          r;
        logic [23:0] len;
        rst_n             = 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.func       <= FUNC_START;
        req_ch.address    <= '0;
        req_ch.length     <= '0;
        req_ch.data_byte  <= '0;
        req_ch.flash_word <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Page erases at the address extremes.
        erase_page(32'h0000_0000);
        erase_page(32'hFFFF_FFFF);
        erase_page(32'h0000_3FFF);
        // Ignored items: unused code, data with no write open.
        send_item(FUNC_UNUSED, 32'hFFFF_FFFF, 24'hFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        data_byte(8'hA5, 32'h1234_5678);
        // Zero length opens nothing.
        start_write(32'h0000_0100, 24'd0);
        data_byte(8'h5A, 32'h8765_4321);
        // Short head: two bytes into a three-lane gap.
        start_write(32'h0000_1001, 24'd2);
        data_byte(8'h00, 32'hFFFF_FFFF);
        data_byte(8'hFF, 32'h0000_0000);
        // Byte address wraps past the top.
        start_write(32'hFFFF_FFFE, 24'd3);
        data_byte(8'h11, 32'hCAFE_F00D);
        data_byte(8'h22, 32'h0000_0000);
        data_byte(8'h33, 32'hFFFF_FFFF);
        // Erase inside an open write, then a start that drops the rest.
        start_write(32'h0000_0002, 24'hFF_FFFF);
        data_byte(8'hFF, 32'h0000_0000);
        erase_page(32'h1234_5678);
        data_byte(8'h00, 32'hFFFF_FFFF);
        start_write(32'h0000_0020, 24'd1);
        data_byte(8'h7E, 32'hFFFF_FFFF);
        settle();

        next_phase_at = items_sent;
        while (items_sent < RANDOM_ITEMS + 20)
        begin
            if (items_sent >= next_phase_at)
            begin
                settle();
                req_idle_on   = ($urandom_range(0, 3) != 0);
                sink_idle_on  = ($urandom_range(0, 3) != 0);
                next_phase_at = items_sent + PHASE_ITEMS;
            end
            r = $urandom_range(0, 99);
            if (r < 6)
                stray_item();
            else if (r < 12)
            begin
                // Broken request: far longer than the bytes that follow.
                len = ($urandom_range(0, 1) == 1) ? 24'hFF_FFFF : 24'($urandom);
                write_request(pick_address(), len, $urandom_range(0, 40));
            end
            else
            begin
                len = pick_length();
                write_request(pick_address(), len, int'(len));
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (board.failures == 0 && board.pending() == 0)
            $display("** flash_write_chunker_core: PASSED **");
        else
            $display("** flash_write_chunker_core: FAILED **");
        $finish;
    end
endmodule

`default_nettype wire
